>>> src/lphash_pkg.sv
// Package for the linear-probing hash table: sizes, codes and the queued request type.
// Used by the channel interfaces and by every module of the block.
package lphash_pkg;

    localparam int TABLE_DEPTH = 8;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int KEY_W       = 31;
    localparam int VAL_W       = 32;
    localparam int STATUS_W    = 2;
    localparam int SLOT_OUT_W  = 3;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_SEARCH = 1'b1;

    localparam logic [STATUS_W-1:0] STATUS_WRITTEN = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL    = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FOUND   = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_MISSING = 2'd3;

    typedef struct packed {
        logic                    opcode;
        logic [KEY_W-1:0]        key;
        logic signed [VAL_W-1:0] value;
        logic [IDX_W-1:0]        home;
    } req_t;

    // The reported slot field carries the low bits of the slot number.
    function automatic logic [SLOT_OUT_W-1:0] slot_field(input logic [IDX_W-1:0] pos);
        logic [IDX_W+SLOT_OUT_W-1:0] ext;
        ext = (IDX_W + SLOT_OUT_W)'(pos);
        return ext[SLOT_OUT_W-1:0];
    endfunction

endpackage

>>> src/lphash_if.sv
// Valid/ready channel interfaces for command words and response words.
// Depends on lphash_pkg for field widths.
interface lphash_cmd_if;
    import lphash_pkg::*;

    logic                    valid;
    logic                    ready;
    logic                    opcode;
    logic [KEY_W-1:0]        key;
    logic signed [VAL_W-1:0] value;

    modport source (output valid, opcode, key, value, input ready);
    modport sink   (input valid, opcode, key, value, output ready);
endinterface

interface lphash_rsp_if;
    import lphash_pkg::*;

    logic                      valid;
    logic                      ready;
    logic [STATUS_W-1:0]       status;
    logic signed [VAL_W-1:0]   found_value;
    logic [SLOT_OUT_W-1:0]     slot_index;

    modport source (output valid, status, found_value, slot_index, input ready);
    modport sink   (input valid, status, found_value, slot_index, output ready);
endinterface

>>> src/lphash_front.sv
// Front end: takes command words and turns each into a queued request with its home slot.
// Depends on lphash_pkg and lphash_cmd_if.
module lphash_front
(
    lphash_cmd_if.sink          cmd,
    output logic                push_valid,
    output lphash_pkg::req_t    push_data,
    input  logic                push_ready
);
    import lphash_pkg::*;

    logic [KEY_W-1:0] home_full;

    // With a power-of-two depth this reduces to a mask of the low key bits.
    assign home_full = cmd.key % KEY_W'(TABLE_DEPTH);

    assign cmd.ready        = push_ready;
    assign push_valid       = cmd.valid;
    assign push_data.opcode = cmd.opcode;
    assign push_data.key    = cmd.key;
    assign push_data.value  = cmd.value;
    assign push_data.home   = home_full[IDX_W-1:0];

endmodule

>>> src/lphash_fifo.sv
// Two-entry request queue between the front end and the probe engine.
// Depends on lphash_pkg for the request type.
module lphash_fifo
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push_valid,
    input  lphash_pkg::req_t    push_data,
    output logic                push_ready,
    output logic                pop_valid,
    output lphash_pkg::req_t    pop_data,
    input  logic                pop_ready
);
    import lphash_pkg::*;

    req_t       entry_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       do_push;
    logic       do_pop;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_data   = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = do_push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(do_push) - 2'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

>>> src/lphash_back.sv
// Probe engine: walks the slot table one slot per cycle and builds the response word.
// Depends on lphash_pkg and lphash_rsp_if; holds the key/value memory and occupied bits.
module lphash_back
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                pop_valid,
    input  lphash_pkg::req_t    pop_data,
    output logic                pop_ready,
    lphash_rsp_if.source        rsp
);
    import lphash_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE  = 2'b01,
        ST_PROBE = 2'b10
    } state_t;

    state_t                  state_reg;
    state_t                  state_next;
    req_t                    req_reg;
    logic [IDX_W-1:0]        pos_reg;
    logic [IDX_W-1:0]        pos_next;
    logic [IDX_W-1:0]        cnt_reg;
    logic [IDX_W-1:0]        cnt_next;
    logic [IDX_W-1:0]        pos_wrap;
    logic [IDX_W-1:0]        rd_addr;

    logic [KEY_W-1:0]        key_mem [TABLE_DEPTH];
    logic signed [VAL_W-1:0] val_mem [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0]  occ_reg;
    logic [KEY_W-1:0]        key_rd_reg;
    logic signed [VAL_W-1:0] val_rd_reg;
    logic                    occ_rd_reg;

    logic                    used;
    logic                    same;
    logic                    hit;
    logic                    last;
    logic                    finish;
    logic                    out_free;
    logic                    fire;
    logic                    do_write;
    logic                    advance;

    logic                    rsp_valid_reg;
    logic [STATUS_W-1:0]     status_reg;
    logic [STATUS_W-1:0]     status_next;
    logic signed [VAL_W-1:0] value_reg;
    logic signed [VAL_W-1:0] value_next;
    logic [SLOT_OUT_W-1:0]   slot_reg;
    logic [SLOT_OUT_W-1:0]   slot_next;

    assign pos_wrap = (pos_reg == IDX_W'(TABLE_DEPTH - 1)) ? '0 : pos_reg + 1'b1;
    assign used     = occ_rd_reg;
    assign same     = used && (key_rd_reg == req_reg.key);
    assign hit      = !used || same;
    assign last     = (cnt_reg == IDX_W'(TABLE_DEPTH - 1));
    assign finish   = (state_reg == ST_PROBE) && (hit || last);
    assign out_free = !rsp_valid_reg || rsp.ready;
    assign fire     = finish && out_free;
    assign do_write = fire && hit && (req_reg.opcode == OP_INSERT);
    assign advance  = (state_reg == ST_PROBE) && !finish;

    assign pop_ready = (state_reg == ST_IDLE);

    // The read address runs one slot ahead of the compare so the registered read of each slot is ready for its compare.
    always_comb
    begin
        if (state_reg == ST_IDLE)
        begin
            rd_addr = pop_data.home;
        end
        else if (advance)
        begin
            rd_addr = pos_wrap;
        end
        else
        begin
            rd_addr = pos_reg;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        pos_next   = pos_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (pop_valid)
                begin
                    state_next = ST_PROBE;
                    pos_next   = pop_data.home;
                    cnt_next   = '0;
                end
            end
            ST_PROBE:
            begin
                if (fire)
                begin
                    state_next = ST_IDLE;
                end
                else if (advance)
                begin
                    pos_next = pos_wrap;
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        status_next = STATUS_MISSING;
        value_next  = '0;
        slot_next   = '0;
        if (req_reg.opcode == OP_INSERT)
        begin
            if (hit)
            begin
                status_next = STATUS_WRITTEN;
                slot_next   = slot_field(pos_reg);
            end
            else
            begin
                status_next = STATUS_FULL;
            end
        end
        else if (same)
        begin
            status_next = STATUS_FOUND;
            value_next  = val_rd_reg;
            slot_next   = slot_field(pos_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pos_reg       <= '0;
            cnt_reg       <= '0;
            occ_reg       <= '0;
            occ_rd_reg    <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            pos_reg    <= pos_next;
            cnt_reg    <= cnt_next;
            occ_rd_reg <= occ_reg[rd_addr];
            if (do_write)
            begin
                occ_reg[pos_reg] <= 1'b1;
            end
            if (fire)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop_valid && pop_ready)
        begin
            req_reg <= pop_data;
        end
        if (fire)
        begin
            status_reg <= status_next;
            value_reg  <= value_next;
            slot_reg   <= slot_next;
        end
        key_rd_reg <= key_mem[rd_addr];
        val_rd_reg <= val_mem[rd_addr];
        if (do_write)
        begin
            key_mem[pos_reg] <= req_reg.key;
            val_mem[pos_reg] <= req_reg.value;
        end
    end

    assign rsp.valid       = rsp_valid_reg;
    assign rsp.status      = status_reg;
    assign rsp.found_value = value_reg;
    assign rsp.slot_index  = slot_reg;

    // Slots are never freed once written.
    a_occ_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        ##1 ((occ_reg & $past(occ_reg)) == $past(occ_reg)))
        else $error("occupied bit cleared");

    // A written slot is marked occupied right after the write.
    a_write_marks: assert property (@(posedge clk) disable iff (!rst_n)
        do_write |=> occ_reg[$past(pos_reg)])
        else $error("written slot not marked occupied");

    // A probe never runs past one full lap of the table.
    a_lap_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_PROBE && last && out_free) |=> (state_reg == ST_IDLE))
        else $error("probe ran past one lap");

    // Each finished probe loads the response register.
    a_rsp_load: assert property (@(posedge clk) disable iff (!rst_n)
        fire |=> rsp_valid_reg)
        else $error("finished probe produced no response");

endmodule

>>> src/linear_probe_hash_table.sv
// Top level of the linear-probing hash table: front end, request queue and probe engine.
// Depends on lphash_pkg, lphash_if, lphash_front, lphash_fifo and lphash_back.
//
// Each command word is an insert or a search of a 31-bit key in a table of TABLE_DEPTH
// key/value slots; every command yields exactly one response word. A word is dequeued and
// then probed one slot per cycle over at most TABLE_DEPTH slots, starting at key modulo
// TABLE_DEPTH and wrapping; the probe rate is set by the single read port of the slot
// memory, which is read once per probe. A two-entry queue lets up to two further command
// words be accepted while a probe runs, and the response register holds a finished word
// while the next probe proceeds. Reset empties the table at once through per-slot
// occupied bits; no clearing pass is needed.
module linear_probe_hash_table
(
    input  logic        clk,
    input  logic        rst_n,
    lphash_cmd_if.sink  cmd,
    lphash_rsp_if.source rsp
);
    import lphash_pkg::*;

    logic push_valid;
    logic push_ready;
    req_t push_data;
    logic pop_valid;
    logic pop_ready;
    req_t pop_data;

    lphash_front u_front
    (
        .cmd        (cmd),
        .push_valid (push_valid),
        .push_data  (push_data),
        .push_ready (push_ready)
    );

    lphash_fifo u_fifo
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_data  (push_data),
        .push_ready (push_ready),
        .pop_valid  (pop_valid),
        .pop_data   (pop_data),
        .pop_ready  (pop_ready)
    );

    lphash_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .pop_valid  (pop_valid),
        .pop_data   (pop_data),
        .pop_ready  (pop_ready),
        .rsp        (rsp)
    );

endmodule

>>> test/linear_probe_hash_table_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for the linear-probing hash table: directed rows, then random words.
// Depends on lphash_pkg, the lphash_if channel interfaces and linear_probe_hash_table.
module linear_probe_hash_table_test;
    import lphash_pkg::*;

    typedef struct packed {
        logic [STATUS_W-1:0]     status;
        logic signed [VAL_W-1:0] found_value;
        logic [SLOT_OUT_W-1:0]   slot_index;
    } rsp_word_t;

    typedef struct {
        logic                    opcode;
        logic [KEY_W-1:0]        key;
        logic signed [VAL_W-1:0] value;
        bit                      typed;
        rsp_word_t               result;
    } stim_row_t;

    localparam int RANDOM_WORDS = 800;
    localparam int LONG_HOLD    = 150;

    logic clk;
    logic rst_n;

    lphash_cmd_if cmd_ch();
    lphash_rsp_if rsp_ch();

    linear_probe_hash_table uut
    (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_ch),
        .rsp   (rsp_ch)
    );

    // Shadow copy of the slot table.
    bit                      held       [TABLE_DEPTH];
    logic [KEY_W-1:0]        held_key   [TABLE_DEPTH];
    logic signed [VAL_W-1:0] held_value [TABLE_DEPTH];

    rsp_word_t pending_responses[$];

    int error_count   = 0;
    int words_sent    = 0;
    int words_back    = 0;
    int status_seen [4] = '{0, 0, 0, 0};
    int input_stalls  = 0;
    int burst_left    = 0;

    // Rows with a typed result are the ones that can be read off directly; the
    // others take their result from the predictor.
    stim_row_t directed_rows [20] = '{
        '{OP_SEARCH, 31'd0, 32'sd0, 1'b1, '{STATUS_MISSING, 32'sd0, 3'd0}},
        '{OP_INSERT, 31'd0, 32'sh7FFFFFFF, 1'b1, '{STATUS_WRITTEN, 32'sd0, 3'd0}},
        '{OP_SEARCH, 31'd0, 32'sd0, 1'b1, '{STATUS_FOUND, 32'sh7FFFFFFF, 3'd0}},
        '{OP_INSERT, 31'h7FFFFFFF, 32'sh80000000, 1'b1, '{STATUS_WRITTEN, 32'sd0, 3'd7}},
        '{OP_SEARCH, 31'h7FFFFFFF, 32'sd0, 1'b1, '{STATUS_FOUND, 32'sh80000000, 3'd7}},
        '{OP_INSERT, 31'd8, -32'sd1, 1'b0, '0},
        '{OP_INSERT, 31'd15, 32'sd5, 1'b0, '0},
        '{OP_SEARCH, 31'd15, 32'sd0, 1'b0, '0},
        '{OP_INSERT, 31'd0, 32'sd123, 1'b0, '0},
        '{OP_SEARCH, 31'd0, 32'sd0, 1'b0, '0},
        '{OP_SEARCH, 31'd16, -32'sd1, 1'b0, '0},
        '{OP_INSERT, 31'd3, 32'sh55555555, 1'b0, '0},
        '{OP_INSERT, 31'd4, 32'shAAAAAAAA, 1'b0, '0},
        '{OP_INSERT, 31'd5, 32'sd0, 1'b0, '0},
        '{OP_INSERT, 31'd6, 32'sd1, 1'b0, '0},
        '{OP_INSERT, 31'd24, 32'sd7, 1'b1, '{STATUS_FULL, 32'sd0, 3'd0}},
        '{OP_SEARCH, 31'd24, 32'sd0, 1'b1, '{STATUS_MISSING, 32'sd0, 3'd0}},
        '{OP_INSERT, 31'd6, -32'sd2, 1'b0, '0},
        '{OP_SEARCH, 31'd6, 32'sd0, 1'b0, '0},
        '{OP_SEARCH, 31'h2AAAAAAA, 32'sd0, 1'b0, '0}
    };

    always #5 clk = ~clk;

    initial
    begin
        #2_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        error_count++;
        if (error_count <= 40)
        begin
            $display("ERROR at %0t: %s", $time, msg);
        end
    endtask

    // Walks the probe sequence from the home slot; an insert also updates the shadow table.
    function automatic rsp_word_t probe_predict(input logic op, input logic [KEY_W-1:0] key,
                                                input logic signed [VAL_W-1:0] value);
        rsp_word_t r;
        int        pos;
        pos = int'(key % KEY_W'(TABLE_DEPTH));
        r = '{STATUS_MISSING, 32'sd0, '0};
        if (op == OP_INSERT)
        begin
            r.status = STATUS_FULL;
        end
        for (int n = 0; n < TABLE_DEPTH; n++)
        begin
            if (op == OP_INSERT && (!held[pos] || held_key[pos] == key))
            begin
                held[pos]       = 1'b1;
                held_key[pos]   = key;
                held_value[pos] = value;
                r.status        = STATUS_WRITTEN;
                r.slot_index    = SLOT_OUT_W'(pos);
                return r;
            end
            if (op == OP_SEARCH && !held[pos])
            begin
                return r;
            end
            if (op == OP_SEARCH && held_key[pos] == key)
            begin
                r.status      = STATUS_FOUND;
                r.found_value = held_value[pos];
                r.slot_index  = SLOT_OUT_W'(pos);
                return r;
            end
            pos = (pos + 1 == TABLE_DEPTH) ? 0 : pos + 1;
        end
        return r;
    endfunction

    // Up to half are keys already in the table, so searches hit and inserts update.
    function automatic logic [KEY_W-1:0] pick_key();
        int slot;
        int pick;
        pick = $urandom_range(0, 9);
        slot = $urandom_range(0, TABLE_DEPTH - 1);
        if (pick <= 4 && held[slot])
        begin
            return held_key[slot];
        end
        if (pick <= 6)
        begin
            return KEY_W'($urandom_range(0, 31));
        end
        if (pick == 7)
        begin
            return $urandom_range(0, 1) ? '1 : '0;
        end
        return KEY_W'($urandom);
    endfunction

    // Offers one word and returns at the edge where it is accepted.
    task automatic offer_word(input logic op, input logic [KEY_W-1:0] key,
                              input logic signed [VAL_W-1:0] value);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                cmd_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        cmd_ch.valid  <= 1'b1;
        cmd_ch.opcode <= op;
        cmd_ch.key    <= key;
        cmd_ch.value  <= value;
        do
            @(posedge clk);
        while (!cmd_ch.ready);
        words_sent++;
    endtask

    initial
    begin
        rsp_word_t        predicted;
        logic             op;
        logic [KEY_W-1:0] key;
        logic signed [VAL_W-1:0] value;

        clk = 1'b0;
        rst_n <= 1'b0;
        cmd_ch.valid  <= 1'b0;
        cmd_ch.opcode <= OP_INSERT;
        cmd_ch.key    <= '0;
        cmd_ch.value  <= '0;
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            held[i] = 1'b0;
        end
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
        begin
            offer_word(directed_rows[i].opcode, directed_rows[i].key, directed_rows[i].value);
            predicted = probe_predict(directed_rows[i].opcode, directed_rows[i].key,
                                      directed_rows[i].value);
            pending_responses.push_back(directed_rows[i].typed ? directed_rows[i].result
                                                               : predicted);
        end

        for (int i = 0; i < RANDOM_WORDS; i++)
        begin
            op  = $urandom_range(0, 1) ? OP_SEARCH : OP_INSERT;
            key = pick_key();
            case ($urandom_range(0, 7))
                0:       value = 32'sh7FFFFFFF;
                1:       value = 32'sh80000000;
                default: value = $urandom;
            endcase
            offer_word(op, key, value);
            pending_responses.push_back(probe_predict(op, key, value));
        end
        cmd_ch.valid <= 1'b0;

        while (pending_responses.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (2 * TABLE_DEPTH + 4) @(posedge clk);

        $display("Sent %0d words and got %0d back: %0d written, %0d full, %0d found, %0d missing.",
                 words_sent, words_back, status_seen[STATUS_WRITTEN], status_seen[STATUS_FULL],
                 status_seen[STATUS_FOUND], status_seen[STATUS_MISSING]);
        $display("Input side was stalled with a word waiting for %0d cycles.", input_stalls);
        if (error_count == 0)
        begin
            $display("[ OK ] regression clean");
        end
        else
        begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    // Response side: stall pattern changes every segment, plus one long hold-off
    // partway through that lets the block fill up and push back on its input.
    initial
    begin
        int  stall_mode;
        int  seg_left;
        int  hold_left;
        int  phase;
        bit  hold_done;
        stall_mode = 0;
        seg_left   = 0;
        hold_left  = 0;
        phase      = 0;
        hold_done  = 1'b0;
        rsp_ch.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (!hold_done && words_back >= 400)
            begin
                hold_done = 1'b1;
                hold_left = LONG_HOLD;
            end
            if (seg_left == 0)
            begin
                stall_mode = $urandom_range(0, 3);
                seg_left   = $urandom_range(20, 80);
            end
            seg_left--;
            phase++;
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_ch.ready <= 1'b0;
            end
            else
            begin
                case (stall_mode)
                    0:       rsp_ch.ready <= 1'b1;
                    1:       rsp_ch.ready <= (phase % 4) != 3;
                    2:       rsp_ch.ready <= $urandom_range(0, 2) != 0;
                    default: rsp_ch.ready <= (phase % 8) < 5;
                endcase
            end
        end
    end

    always @(posedge clk)
    begin
        rsp_word_t want;
        if (rst_n && cmd_ch.valid && !cmd_ch.ready)
        begin
            input_stalls++;
        end
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            words_back++;
            status_seen[rsp_ch.status]++;
            if (pending_responses.size() == 0)
            begin
                report_mismatch($sformatf("unexpected response word, status %0d",
                                          rsp_ch.status));
            end
            else
            begin
                want = pending_responses.pop_front();
                if (rsp_ch.status !== want.status)
                begin
                    report_mismatch($sformatf("word %0d status %0d, expected %0d",
                                              words_back, rsp_ch.status, want.status));
                end
                if (rsp_ch.found_value !== want.found_value)
                begin
                    report_mismatch($sformatf("word %0d found_value %h, expected %h",
                                              words_back, rsp_ch.found_value,
                                              want.found_value));
                end
                if (rsp_ch.slot_index !== want.slot_index)
                begin
                    report_mismatch($sformatf("word %0d slot_index %0d, expected %0d",
                                              words_back, rsp_ch.slot_index,
                                              want.slot_index));
                end
            end
        end
    end

endmodule

>>> files.f
src/lphash_pkg.sv
src/lphash_if.sv
src/lphash_front.sv
src/lphash_fifo.sv
src/lphash_back.sv
src/linear_probe_hash_table.sv
test/linear_probe_hash_table_test.sv
